### src/b64e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package b64e_pkg;

  localparam int unsigned JobQueueDepth = 2;

  localparam logic [7:0] PadChar = 8'h3D;

  typedef struct packed {
    logic [23:0] group;
    logic [1:0]  npad;
    logic        eot;
  } job_t;

  function automatic logic [7:0] b64_symbol(input logic [5:0] six);
    logic [7:0] s;
    s = {2'b00, six};
    if (six < 6'd26) begin
      return 8'h41 + s;
    end else if (six < 6'd52) begin
      return 8'h61 + (s - 8'd26);
    end else if (six < 6'd62) begin
      return 8'h30 + (s - 8'd52);
    end else if (six == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage
`default_nettype wire

### src/b64e_front.sv
`timescale 1ns / 1ps
`default_nettype none
module b64e_front
  import b64e_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       final_byte_i,
  output logic            job_push_o,
  output job_t            job_o
);

  logic [15:0] pend_q, pend_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [15:0] pend_new;
  logic [1:0]  cnt_new;

  always_comb begin
    pend_new   = (cnt_q == 2'd0) ? {data_byte_i, 8'h00} : {pend_q[15:8], data_byte_i};
    cnt_new    = cnt_q + 2'd1;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    job_push_o = 1'b0;
    job_o      = '{group: {pend_q, data_byte_i}, npad: 2'd0, eot: final_byte_i};
    if (accept_i) begin
      if (cnt_q[1]) begin
        job_push_o = 1'b1;
        pend_d     = '0;
        cnt_d      = '0;
      end else if (final_byte_i) begin
        job_push_o = 1'b1;
        job_o      = '{group: {pend_new, 8'h00},
                       npad: (cnt_new == 2'd1) ? 2'd2 : 2'd1, eot: 1'b1};
        pend_d     = '0;
        cnt_d      = '0;
      end else begin
        pend_d = pend_new;
        cnt_d  = cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      cnt_q  <= '0;
    end else begin
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("pending count out of range");
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && final_byte_i |=> cnt_q == 2'd0)
    else $error("final byte left pending state");
  a_final_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && final_byte_i |-> job_push_o && job_o.eot)
    else $error("final byte produced no closing group");

endmodule
`default_nettype wire

### src/b64e_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module b64e_queue
  import b64e_pkg::*;
#(
  parameter int unsigned Depth = JobQueueDepth
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output job_t      data_o
);

  localparam int unsigned AW = $clog2(Depth);

  job_t            mem_q [Depth];
  logic [AW-1:0]   wr_q, rd_q;
  logic [AW:0]     cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("job queue underflow");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(Depth))
    else $error("job queue count out of range");

endmodule
`default_nettype wire

### src/b64e_back.sv
`timescale 1ns / 1ps
`default_nettype none
module b64e_back
  import b64e_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  input  wire job_t job_i,
  output logic      job_pop_o,
  input  wire logic pop_i,
  output logic      empty_o,
  output logic [7:0] out_char_o,
  output logic      end_of_text_o
);

  logic [1:0] k_q;
  logic       ov_q;
  logic [7:0] char_q, char_d;
  logic       eot_q, eot_d;
  logic       load;
  logic [5:0] six;
  logic       is_pad;

  assign load      = job_valid_i && (!ov_q || pop_i);
  assign job_pop_o = load && (k_q == 2'd3);

  always_comb begin
    unique case (k_q)
      2'd0:    six = job_i.group[23:18];
      2'd1:    six = job_i.group[17:12];
      2'd2:    six = job_i.group[11:6];
      default: six = job_i.group[5:0];
    endcase
    is_pad = ((k_q == 2'd3) && (job_i.npad != 2'd0)) ||
             ((k_q == 2'd2) && (job_i.npad == 2'd2));
    char_d = is_pad ? PadChar : b64_symbol(six);
    eot_d  = job_i.eot && (k_q == 2'd3);
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= char_d;
      eot_q  <= eot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q  <= '0;
      ov_q <= 1'b0;
    end else begin
      if (load) begin
        k_q  <= k_q + 2'd1;
        ov_q <= 1'b1;
      end else if (pop_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign empty_o       = !ov_q;
  assign out_char_o    = char_q;
  assign end_of_text_o = eot_q;

  a_eot_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && eot_d |=> k_q == 2'd0)
    else $error("end of text off group boundary");
  a_first_not_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && k_q == 2'd0 |=> out_char_o != PadChar)
    else $error("pad in first position");
  a_held_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !pop_i |=> ov_q && $stable(out_char_o))
    else $error("result changed while waiting");

endmodule
`default_nettype wire

### src/base64_stream_encoder.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Handshake (taken when)  | Fields
// input   | push_i && !full_o       | data_byte_i[7:0], final_byte_i
// result  | pop_i && !empty_o       | out_char_o[7:0], end_of_text_o
//
// One byte accepted per cycle while the job queue has room.
// Results leave at one character per cycle while the receiver takes them,
// four per group of three bytes, so the character stage sets the sustained rate.
// A byte reaches the result ports through the job queue and the character register.
// Reset clears the pending bytes, the job queue and the result valid flag.
// A held result stalls the character stage, then the queue, then full_o.
module base64_stream_encoder
  import b64e_pkg::*;
#(
  parameter int unsigned QueueDepth = JobQueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  output logic            full_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       final_byte_i,
  input  wire logic       pop_i,
  output logic            empty_o,
  output logic [7:0]      out_char_o,
  output logic            end_of_text_o
);

  logic job_push, job_valid, job_pop;
  job_t job_in, job_out;

  b64e_front u_front (
    .clk_i,
    .rst_ni,
    .accept_i     (push_i && !full_o),
    .data_byte_i,
    .final_byte_i,
    .job_push_o   (job_push),
    .job_o        (job_in)
  );

  b64e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full_o),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .data_o  (job_out)
  );

  b64e_back u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i   (job_valid),
    .job_i         (job_out),
    .job_pop_o     (job_pop),
    .pop_i         (pop_i && !empty_o),
    .empty_o,
    .out_char_o,
    .end_of_text_o
  );

endmodule
`default_nettype wire

### test/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps
module base64_stream_encoder_tb;
  import b64e_pkg::PadChar;

  localparam int unsigned StallLimit = 1000;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } enc_char_t;

  class b64_scoreboard;
    string       alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    logic [15:0] held_bytes;
    logic [1:0]  held_count;
    enc_char_t   want_q[$];
    int          fails;
    int          chars_ok;
    int          msgs;

    function new();
      held_bytes = '0;
      held_count = '0;
      fails      = 0;
      chars_ok   = 0;
      msgs       = 0;
    endfunction

    function logic [7:0] sym6(logic [5:0] v);
      return alphabet[v];
    endfunction

    function void add_char(logic [7:0] c, logic e);
      enc_char_t item;
      item.ch  = c;
      item.eot = e;
      want_q.push_back(item);
    endfunction

    // models the encoder on one accepted byte and queues the characters it yields
    function void note_byte(logic [7:0] d, logic fin);
      logic [7:0] b0;
      logic [7:0] b1;
      b0 = held_bytes[15:8];
      b1 = held_bytes[7:0];
      if (held_count >= 2'd2) begin
        add_char(sym6(b0[7:2]), 1'b0);
        add_char(sym6({b0[1:0], b1[7:4]}), 1'b0);
        add_char(sym6({b1[3:0], d[7:6]}), 1'b0);
        add_char(sym6(d[5:0]), fin);
        held_bytes = '0;
        held_count = '0;
        if (fin) msgs++;
        return;
      end
      if (held_count == 2'd0) held_bytes = {d, 8'h00};
      else held_bytes[7:0] = d;
      held_count++;
      if (!fin) return;
      msgs++;
      b0 = held_bytes[15:8];
      b1 = held_bytes[7:0];
      add_char(sym6(b0[7:2]), 1'b0);
      if (held_count == 2'd1) begin
        add_char(sym6({b0[1:0], 4'h0}), 1'b0);
        add_char(PadChar, 1'b0);
      end else begin
        add_char(sym6({b0[1:0], b1[7:4]}), 1'b0);
        add_char(sym6({b1[3:0], 2'b00}), 1'b0);
      end
      add_char(PadChar, 1'b1);
      held_bytes = '0;
      held_count = '0;
    endfunction

    function void check_char(logic [7:0] c, logic e);
      enc_char_t want;
      if (want_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected char: expected none, got %h eot %b", $time, c, e);
        return;
      end
      want = want_q.pop_front();
      if (want.ch !== c) begin
        fails++;
        $display("%0t: out_char mismatch: expected %h, got %h", $time, want.ch, c);
      end
      if (want.eot !== e) begin
        fails++;
        $display("%0t: end_of_text mismatch: expected %b, got %b", $time, want.eot, e);
      end
      if (want.ch === c && want.eot === e) chars_ok++;
    endfunction

    function int waiting();
      return want_q.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push_i = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       final_byte_i = 1'b0;
  logic       pop_i = 1'b0;
  logic       full_o;
  logic       empty_o;
  logic [7:0] out_char_o;
  logic       end_of_text_o;

  b64_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_len = 0;
  int bytes_in = 0;
  int quiet_cycles = 0;

  base64_stream_encoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push_i),
    .full_o        (full_o),
    .data_byte_i   (data_byte_i),
    .final_byte_i  (final_byte_i),
    .pop_i         (pop_i),
    .empty_o       (empty_o),
    .out_char_o    (out_char_o),
    .end_of_text_o (end_of_text_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [7:0] d, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(negedge clk_i);
    end
    push_i       <= 1'b1;
    data_byte_i  <= d;
    final_byte_i <= fin;
    do @(posedge clk_i); while (full_o);
    sb.note_byte(d, fin);
    bytes_in++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), i == len - 1);
  endtask

  task automatic send_random(input int n_bytes);
    int stop_at;
    stop_at = bytes_in + n_bytes;
    while (bytes_in < stop_at) begin
      if ($urandom_range(7) == 0) send_message($urandom_range(30, 10));
      else send_message($urandom_range(9, 1));
    end
  endtask

  // receiver: random pop requests, plus a long hold when one is asked for
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_len > 0) begin
        stall_len--;
        pop_i <= 1'b0;
      end else begin
        pop_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && pop_i && !empty_o) sb.check_char(out_char_o, end_of_text_o);
  end

  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no request taken for %0d cycles", $time, quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: full group, one and two left over, extreme bytes
    send_text("Man");
    send_text("Ma");
    send_text("M");
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFB, 1'b1);
    send_text("foobar");

    send_idle_pct = 20;
    recv_idle_pct = 73;
    send_random(40);
    send_idle_pct = 73;
    recv_idle_pct = 20;
    send_random(40);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(40);

    // hold the receiver off so the block backs up onto push
    @(posedge clk_i);
    stall_len = 80;
    @(negedge clk_i);
    send_message(24);
    push_i <= 1'b0;

    while (sb.waiting() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Encoded %0d bytes in %0d messages; %0d characters matched.",
             bytes_in, sb.msgs, sb.chars_ok);
    $display("Covered padding of one and two, completed groups, idle gaps and a backed-up stall.");
    if (sb.fails == 0 && sb.waiting() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
src/b64e_pkg.sv
src/b64e_front.sv
src/b64e_queue.sv
src/b64e_back.sv
src/base64_stream_encoder.sv
test/base64_stream_encoder_tb.sv
